// ===== rtl/lom_pkg.sv =====
// Shared constants for the limit order matcher: report status codes, side codes and default sizes.
package lom_pkg;

    // Default sizes
    localparam int DEF_BOOK_DEPTH = 16;
    localparam int DEF_PRICE_BITS = 16;
    localparam int DEF_QTY_BITS   = 16;
    localparam int ID_BITS        = 16;
    localparam int STATUS_BITS    = 2;

    // Report status codes
    localparam logic [STATUS_BITS-1:0] ST_NEW      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_REJECTED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FILLED   = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_PARTIAL  = 2'd3;

    // Order side codes, also the book half in memory
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

endpackage

// ===== rtl/lom_book_mem.sv =====
// Book storage: one synchronous RAM holding both halves of the book, registered read.
module lom_book_mem #(
    parameter int AW = 5,
    parameter int DW = 48
) (
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lom_ctrl.sv =====
// Matching sequencer: walks the book through the RAM, builds reports, drives the output register.
module lom_ctrl #(
    parameter int BOOK_DEPTH = 16,
    parameter int PRICE_BITS = 16,
    parameter int QTY_BITS   = 16,
    localparam int IW = $clog2(BOOK_DEPTH),
    localparam int CW = $clog2(BOOK_DEPTH + 1),
    localparam int AW = IW + 1,
    localparam int EW = lom_pkg::ID_BITS + PRICE_BITS + QTY_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // incoming order
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [lom_pkg::ID_BITS-1:0]      in_id,
    input  logic                             in_side,
    input  logic [PRICE_BITS-1:0]            in_price,
    input  logic [QTY_BITS-1:0]              in_qty,
    // report out
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [lom_pkg::ID_BITS-1:0]      out_id,
    output logic                             out_side,
    output logic [PRICE_BITS-1:0]            out_price,
    output logic [QTY_BITS-1:0]              out_qty,
    output logic [lom_pkg::STATUS_BITS-1:0]  out_status,
    output logic                             out_last,
    // book RAM
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    input  logic [EW-1:0]                    mem_rdata,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [EW-1:0]                    mem_wdata
);
    import lom_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MRD  = 4'd1;
    localparam logic [3:0] S_MCHK = 4'd2;
    localparam logic [3:0] S_MB   = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CWR  = 4'd5;
    localparam logic [3:0] S_REST = 4'd6;
    localparam logic [3:0] S_IRD  = 4'd7;
    localparam logic [3:0] S_ICHK = 4'd8;
    localparam logic [3:0] S_IWR  = 4'd9;
    localparam logic [3:0] S_FIN  = 4'd10;

    localparam logic [CW-1:0] CNT_FULL = CW'(BOOK_DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [3:0]              state_reg, state_next;
    logic [ID_BITS-1:0]      id_reg, id_next;
    logic                    side_reg, side_next;
    logic [PRICE_BITS-1:0]   price_reg, price_next;
    logic [QTY_BITS-1:0]     qty_reg, qty_next;
    logic                    matched_reg, matched_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [CW-1:0]           bid_cnt_reg, bid_cnt_next;
    logic [CW-1:0]           ask_cnt_reg, ask_cnt_next;
    logic [PRICE_BITS-1:0]   tp_reg, tp_next;
    logic [QTY_BITS-1:0]     fill_reg, fill_next;
    logic [QTY_BITS-1:0]     rem_reg, rem_next;

    // pending report, held back until it is known whether it is the last
    logic                    pv_reg, pv_next;
    logic [ID_BITS-1:0]      pid_reg, pid_next;
    logic                    pside_reg, pside_next;
    logic [PRICE_BITS-1:0]   pprice_reg, pprice_next;
    logic [QTY_BITS-1:0]     pqty_reg, pqty_next;
    logic [STATUS_BITS-1:0]  pst_reg, pst_next;

    // output register
    logic                    ov_reg, ov_next;
    logic [ID_BITS-1:0]      oid_reg, oid_next;
    logic                    oside_reg, oside_next;
    logic [PRICE_BITS-1:0]   oprice_reg, oprice_next;
    logic [QTY_BITS-1:0]     oqty_reg, oqty_next;
    logic [STATUS_BITS-1:0]  ost_reg, ost_next;
    logic                    olast_reg, olast_next;

    // new report request
    logic                    push, flush;
    logic [ID_BITS-1:0]      n_id;
    logic                    n_side;
    logic [PRICE_BITS-1:0]   n_price;
    logic [QTY_BITS-1:0]     n_qty;
    logic [STATUS_BITS-1:0]  n_st;

    logic                    out_free, can_push;
    logic                    opp, own;
    logic [CW-1:0]           opp_cnt, own_cnt;
    logic [ID_BITS-1:0]      e_id;
    logic [PRICE_BITS-1:0]   e_price;
    logic [QTY_BITS-1:0]     e_qty;
    logic                    crosses, goes_ahead;
    logic [QTY_BITS-1:0]     fill;
    logic [CW:0]             jk_sum;
    logic [CW-1:0]           j_inc;

    assign opp        = ~side_reg;
    assign own        = side_reg;
    assign opp_cnt    = (opp == SIDE_BUY) ? bid_cnt_reg : ask_cnt_reg;
    assign own_cnt    = (own == SIDE_BUY) ? bid_cnt_reg : ask_cnt_reg;
    assign e_id       = mem_rdata[EW-1 -: ID_BITS];
    assign e_price    = mem_rdata[PRICE_BITS+QTY_BITS-1 -: PRICE_BITS];
    assign e_qty      = mem_rdata[QTY_BITS-1:0];
    assign crosses    = (side_reg == SIDE_BUY) ? (e_price <= price_reg) : (price_reg <= e_price);
    assign goes_ahead = (side_reg == SIDE_BUY) ? (price_reg >= e_price) : (e_price >= price_reg);
    assign fill       = (qty_reg >= e_qty) ? e_qty : qty_reg;
    assign jk_sum     = {1'b0, j_reg} + {1'b0, k_reg};
    assign j_inc      = j_reg + CNT_ONE;
    assign out_free   = !ov_reg || out_ready;
    assign can_push   = !pv_reg || out_free;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        id_next      = id_reg;
        side_next    = side_reg;
        price_next   = price_reg;
        qty_next     = qty_reg;
        matched_next = matched_reg;
        k_next       = k_reg;
        j_next       = j_reg;
        bid_cnt_next = bid_cnt_reg;
        ask_cnt_next = ask_cnt_reg;
        tp_next      = tp_reg;
        fill_next    = fill_reg;
        rem_next     = rem_reg;
        in_ready     = 1'b0;
        push         = 1'b0;
        flush        = 1'b0;
        n_id         = id_reg;
        n_side       = side_reg;
        n_price      = price_reg;
        n_qty        = qty_reg;
        n_st         = ST_REJECTED;
        mem_re       = 1'b0;
        mem_raddr    = '0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = mem_rdata;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    id_next      = in_id;
                    side_next    = in_side;
                    price_next   = in_price;
                    qty_next     = in_qty;
                    matched_next = 1'b0;
                    k_next       = '0;
                    if (in_qty == '0)
                    begin
                        // zero quantity is rejected outright
                        push       = 1'b1;
                        n_id       = in_id;
                        n_side     = in_side;
                        n_price    = in_price;
                        n_qty      = '0;
                        n_st       = ST_REJECTED;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MRD;
                    end
                end
            end

            S_MRD:
            begin
                if (k_reg < opp_cnt)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {opp, k_reg[IW-1:0]};
                    state_next = S_MCHK;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_CRD;
                end
            end

            // best resting entry is in the read register
            S_MCHK:
            begin
                if (!crosses)
                begin
                    j_next     = '0;
                    state_next = S_CRD;
                end
                else if (can_push)
                begin
                    tp_next      = (side_reg == SIDE_BUY) ? price_reg : e_price;
                    fill_next    = fill;
                    rem_next     = e_qty - fill;
                    qty_next     = qty_reg - fill;
                    matched_next = 1'b1;
                    push         = 1'b1;
                    n_price      = (side_reg == SIDE_BUY) ? price_reg : e_price;
                    n_qty        = fill;
                    n_st         = (qty_reg == fill) ? ST_FILLED : ST_PARTIAL;
                    // write back the resting remainder
                    mem_we       = 1'b1;
                    mem_waddr    = {opp, k_reg[IW-1:0]};
                    mem_wdata    = {e_id, e_price, e_qty - fill};
                    state_next   = S_MB;
                end
            end

            // report for the resting side
            S_MB:
            begin
                if (can_push)
                begin
                    push    = 1'b1;
                    n_id    = e_id;
                    n_side  = opp;
                    n_price = tp_reg;
                    n_qty   = fill_reg;
                    n_st    = (rem_reg == '0) ? ST_FILLED : ST_PARTIAL;
                    if (rem_reg == '0)
                    begin
                        k_next = k_reg + CNT_ONE;
                    end
                    if (rem_reg == '0 && qty_reg != '0)
                    begin
                        state_next = S_MRD;
                    end
                    else
                    begin
                        j_next     = '0;
                        state_next = S_CRD;
                    end
                end
            end

            // close the gap left by the removed prefix
            S_CRD:
            begin
                if (k_reg != '0 && jk_sum < {1'b0, opp_cnt})
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {opp, jk_sum[IW-1:0]};
                    state_next = S_CWR;
                end
                else
                begin
                    if (opp == SIDE_BUY)
                    begin
                        bid_cnt_next = bid_cnt_reg - k_reg;
                    end
                    else
                    begin
                        ask_cnt_next = ask_cnt_reg - k_reg;
                    end
                    state_next = S_REST;
                end
            end

            S_CWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = {opp, j_reg[IW-1:0]};
                mem_wdata  = mem_rdata;
                j_next     = j_inc;
                state_next = S_CRD;
            end

            S_REST:
            begin
                if (qty_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (own_cnt == CNT_FULL)
                begin
                    if (can_push)
                    begin
                        push       = 1'b1;
                        n_st       = ST_REJECTED;
                        state_next = S_FIN;
                    end
                end
                else if (own_cnt == '0)
                begin
                    j_next     = '0;
                    state_next = S_IWR;
                end
                else
                begin
                    j_next     = own_cnt - CNT_ONE;
                    state_next = S_IRD;
                end
            end

            // insertion: move entries up from the tail until the slot is found
            S_IRD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = {own, j_reg[IW-1:0]};
                state_next = S_ICHK;
            end

            S_ICHK:
            begin
                if (goes_ahead)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {own, j_inc[IW-1:0]};
                    mem_wdata = mem_rdata;
                    if (j_reg == '0)
                    begin
                        state_next = S_IWR;
                    end
                    else
                    begin
                        j_next     = j_reg - CNT_ONE;
                        state_next = S_IRD;
                    end
                end
                else
                begin
                    j_next     = j_inc;
                    state_next = S_IWR;
                end
            end

            S_IWR:
            begin
                if (matched_reg || can_push)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = {own, j_reg[IW-1:0]};
                    mem_wdata = {id_reg, price_reg, qty_reg};
                    if (own == SIDE_BUY)
                    begin
                        bid_cnt_next = bid_cnt_reg + CNT_ONE;
                    end
                    else
                    begin
                        ask_cnt_next = ask_cnt_reg + CNT_ONE;
                    end
                    push       = !matched_reg;
                    n_st       = ST_NEW;
                    state_next = S_FIN;
                end
            end

            // release the held report as the last one
            S_FIN:
            begin
                if (!pv_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    flush      = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Pending report and output register
    always_comb
    begin
        pv_next     = pv_reg;
        pid_next    = pid_reg;
        pside_next  = pside_reg;
        pprice_next = pprice_reg;
        pqty_next   = pqty_reg;
        pst_next    = pst_reg;
        ov_next     = ov_reg && !out_ready;
        oid_next    = oid_reg;
        oside_next  = oside_reg;
        oprice_next = oprice_reg;
        oqty_next   = oqty_reg;
        ost_next    = ost_reg;
        olast_next  = olast_reg;

        if ((push && pv_reg) || flush)
        begin
            ov_next     = 1'b1;
            oid_next    = pid_reg;
            oside_next  = pside_reg;
            oprice_next = pprice_reg;
            oqty_next   = pqty_reg;
            ost_next    = pst_reg;
            olast_next  = flush;
        end
        if (flush)
        begin
            pv_next = 1'b0;
        end
        if (push)
        begin
            pv_next     = 1'b1;
            pid_next    = n_id;
            pside_next  = n_side;
            pprice_next = n_price;
            pqty_next   = n_qty;
            pst_next    = n_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            id_reg      <= '0;
            side_reg    <= 1'b0;
            price_reg   <= '0;
            qty_reg     <= '0;
            matched_reg <= 1'b0;
            k_reg       <= '0;
            j_reg       <= '0;
            bid_cnt_reg <= '0;
            ask_cnt_reg <= '0;
            tp_reg      <= '0;
            fill_reg    <= '0;
            rem_reg     <= '0;
            pv_reg      <= 1'b0;
            pid_reg     <= '0;
            pside_reg   <= 1'b0;
            pprice_reg  <= '0;
            pqty_reg    <= '0;
            pst_reg     <= ST_NEW;
            ov_reg      <= 1'b0;
            oid_reg     <= '0;
            oside_reg   <= 1'b0;
            oprice_reg  <= '0;
            oqty_reg    <= '0;
            ost_reg     <= ST_NEW;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            id_reg      <= id_next;
            side_reg    <= side_next;
            price_reg   <= price_next;
            qty_reg     <= qty_next;
            matched_reg <= matched_next;
            k_reg       <= k_next;
            j_reg       <= j_next;
            bid_cnt_reg <= bid_cnt_next;
            ask_cnt_reg <= ask_cnt_next;
            tp_reg      <= tp_next;
            fill_reg    <= fill_next;
            rem_reg     <= rem_next;
            pv_reg      <= pv_next;
            pid_reg     <= pid_next;
            pside_reg   <= pside_next;
            pprice_reg  <= pprice_next;
            pqty_reg    <= pqty_next;
            pst_reg     <= pst_next;
            ov_reg      <= ov_next;
            oid_reg     <= oid_next;
            oside_reg   <= oside_next;
            oprice_reg  <= oprice_next;
            oqty_reg    <= oqty_next;
            ost_reg     <= ost_next;
            olast_reg   <= olast_next;
        end
    end

    assign out_valid  = ov_reg;
    assign out_id     = oid_reg;
    assign out_side   = oside_reg;
    assign out_price  = oprice_reg;
    assign out_qty    = oqty_reg;
    assign out_status = ost_reg;
    assign out_last   = olast_reg;

endmodule

// ===== rtl/limit_order_matcher.sv =====
// Top level of the limit order matcher: stream ports, sequencer and book RAM.
//
// Slave channel (s_axis_*): one limit order per beat. Master channel
// (m_axis_*): execution reports, tlast set on the final report of an order.
// Each match yields two reports, incoming order first, then the resting one;
// an order that rests without matching yields a "new" report, one that finds
// its side full (or has zero quantity) a "rejected" report.
// Both book halves live in one synchronous RAM with a registered read port.
// An order is worked on alone: tready is high only between orders. Each
// matched entry is read, checked and written back with its remainder, then
// its resting report is sent; closing the gap of removed entries reads and
// writes each entry moved, as does inserting the remainder from the tail.
// Reports pass through a one-report hold stage and an output register; when
// the receiver stalls the sequencer waits, nothing is dropped.
// Reset empties both sides of the book at once (counts cleared); no RAM
// clearing pass is needed.
module limit_order_matcher #(
    parameter int BOOK_DEPTH = lom_pkg::DEF_BOOK_DEPTH,
    parameter int PRICE_BITS = lom_pkg::DEF_PRICE_BITS,
    parameter int QTY_BITS   = lom_pkg::DEF_QTY_BITS,
    localparam int FW = lom_pkg::ID_BITS + 1 + PRICE_BITS + QTY_BITS,
    localparam int TW = ((FW + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // order_id, side, price, quantity (low to high)
    input  logic [TW-1:0]                   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // report_id, report_side, report_price, report_quantity (low to high)
    output logic [TW-1:0]                   m_axis_tdata,
    // report_status
    output logic [lom_pkg::STATUS_BITS-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import lom_pkg::*;

    localparam int IW = $clog2(BOOK_DEPTH);
    localparam int AW = IW + 1;
    localparam int EW = ID_BITS + PRICE_BITS + QTY_BITS;

    logic                   mem_re, mem_we;
    logic [AW-1:0]          mem_raddr, mem_waddr;
    logic [EW-1:0]          mem_rdata, mem_wdata;
    logic [ID_BITS-1:0]     out_id;
    logic                   out_side;
    logic [PRICE_BITS-1:0]  out_price;
    logic [QTY_BITS-1:0]    out_qty;

    lom_ctrl #(
        .BOOK_DEPTH (BOOK_DEPTH),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_id      (s_axis_tdata[ID_BITS-1:0]),
        .in_side    (s_axis_tdata[ID_BITS]),
        .in_price   (s_axis_tdata[ID_BITS+PRICE_BITS:ID_BITS+1]),
        .in_qty     (s_axis_tdata[FW-1:ID_BITS+1+PRICE_BITS]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_id     (out_id),
        .out_side   (out_side),
        .out_price  (out_price),
        .out_qty    (out_qty),
        .out_status (m_axis_tuser),
        .out_last   (m_axis_tlast),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata)
    );

    lom_book_mem #(
        .AW (AW),
        .DW (EW)
    ) u_mem (
        .clk   (clk),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata)
    );

    // Pack the report beat
    assign m_axis_tdata = TW'({out_qty, out_price, out_side, out_id});

endmodule

// ===== verif/tb_limit_order_matcher.sv =====
// Testbench for limit_order_matcher: order stream in, execution reports checked against a book model.
`timescale 1ns / 1ps

module tb_limit_order_matcher;
    import lom_pkg::*;

    localparam int DEPTH = DEF_BOOK_DEPTH;
    localparam int TW = 56;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [15:0] id;
        logic        side;
        logic [15:0] price;
        logic [15:0] qty;
    } order_t;

    typedef struct packed {
        logic [15:0]            id;
        logic                   side;
        logic [15:0]            price;
        logic [15:0]            qty;
        logic [STATUS_BITS-1:0] status;
        logic                   last;
    } report_t;

    typedef struct {
        logic [15:0] id;
        logic [15:0] price;
        logic [15:0] qty;
    } entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [TW-1:0] m_axis_tdata;
    logic [STATUS_BITS-1:0] m_axis_tuser;
    logic m_axis_tlast;

    limit_order_matcher dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #10 clk = ~clk;

    // Pending orders, expected reports, model book
    order_t  order_q[$];
    report_t report_q[$];
    entry_t  book[2][DEPTH];
    int      book_cnt[2];

    int send_idle_pct = 14;
    int recv_idle_pct = 72;
    int recv_hold = 0;
    logic in_taken = 1'b0;
    int errors = 0;
    int orders_sent = 0;
    int reports_seen = 0;
    int n_fills = 0;
    int n_rejects = 0;
    int stall_cycles = 0;

    // Book model: match against opposite side, then rest or reject the remainder
    task automatic match_order(input order_t o);
        logic        opp;
        logic [15:0] left;
        logic [15:0] tp;
        logic [15:0] fill;
        logic        crosses;
        logic        matched;
        int          i;
        int          pos;
        report_t     r;
        opp = ~o.side;
        left = o.qty;
        matched = 1'b0;
        i = 0;
        if (o.qty == 0) begin
            r = '{o.id, o.side, o.price, 16'd0, ST_REJECTED, 1'b1};
            report_q.insert(report_q.size(), r);
            return;
        end
        while (i < book_cnt[opp] && left > 0) begin
            crosses = (o.side == SIDE_BUY) ? (book[opp][i].price <= o.price)
                                           : (o.price <= book[opp][i].price);
            if (!crosses)
                break;
            tp = (o.side == SIDE_BUY) ? o.price : book[opp][i].price;
            fill = (left >= book[opp][i].qty) ? book[opp][i].qty : left;
            left -= fill;
            book[opp][i].qty -= fill;
            r = '{o.id, o.side, tp, fill, (left == 0) ? ST_FILLED : ST_PARTIAL, 1'b0};
            report_q.insert(report_q.size(), r);
            r = '{book[opp][i].id, opp, tp, fill,
                  (book[opp][i].qty == 0) ? ST_FILLED : ST_PARTIAL, 1'b0};
            report_q.insert(report_q.size(), r);
            matched = 1'b1;
            if (book[opp][i].qty == 0) begin
                for (int k = i; k < book_cnt[opp] - 1; k++)
                    book[opp][k] = book[opp][k + 1];
                book_cnt[opp]--;
            end else begin
                i++;
            end
        end
        if (left > 0) begin
            if (book_cnt[o.side] >= DEPTH) begin
                r = '{o.id, o.side, o.price, left, ST_REJECTED, 1'b0};
                report_q.insert(report_q.size(), r);
            end else begin
                pos = 0;
                while (pos < book_cnt[o.side]) begin
                    if (o.side == SIDE_BUY ? (o.price >= book[o.side][pos].price)
                                           : (book[o.side][pos].price >= o.price))
                        break;
                    pos++;
                end
                for (int k = book_cnt[o.side]; k > pos; k--)
                    book[o.side][k] = book[o.side][k - 1];
                book[o.side][pos] = '{o.id, o.price, left};
                book_cnt[o.side]++;
                if (!matched) begin
                    r = '{o.id, o.side, o.price, left, ST_NEW, 1'b0};
                    report_q.insert(report_q.size(), r);
                end
            end
        end
        report_q[report_q.size() - 1].last = 1'b1;
    endtask

    // Random order: mostly a tight price band so books cross, some full-range noise
    function automatic order_t rand_order();
        order_t o;
        int mode;
        mode = $urandom_range(0, 39);
        o.id = 16'($urandom);
        o.side = 1'($urandom_range(0, 1));
        if (mode == 0) begin
            o.price = 16'($urandom);
            o.qty = 16'd0;
        end else if (mode < 5) begin
            o.price = 16'($urandom);
            o.qty = 16'($urandom_range(1, 65535));
        end else if (mode < 7) begin
            o.price = 16'($urandom_range(990, 1010));
            o.qty = 16'($urandom_range(200, 65535));
        end else begin
            o.price = 16'($urandom_range(990, 1010));
            o.qty = 16'($urandom_range(1, 40));
        end
        return o;
    endfunction

    // Driver: new beat at falling edge once the previous one was taken
    always @(negedge clk) begin
        if (s_axis_tvalid && !in_taken) begin
            s_axis_tvalid <= 1'b1;
        end else if (order_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            order_t o;
            o = order_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {7'd0, o.qty, o.price, o.side, o.id};
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver backpressure, with an optional long hold-off
    always @(negedge clk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Input monitor: predict reports for each accepted order
    always @(posedge clk) begin
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            order_t o;
            o.id = s_axis_tdata[15:0];
            o.side = s_axis_tdata[16];
            o.price = s_axis_tdata[32:17];
            o.qty = s_axis_tdata[48:33];
            match_order(o);
            orders_sent++;
        end
        if (s_axis_tvalid && !s_axis_tready)
            stall_cycles++;
    end

    // Output monitor: compare each report beat with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            report_t got;
            report_t exp_r;
            got = '{m_axis_tdata[15:0], m_axis_tdata[16], m_axis_tdata[32:17],
                    m_axis_tdata[48:33], m_axis_tuser, m_axis_tlast};
            reports_seen++;
            if (report_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected report id=%0h side=%0d price=%0d qty=%0d st=%0d last=%0d",
                             got.id, got.side, got.price, got.qty, got.status, got.last);
            end else begin
                exp_r = report_q.pop_front();
                if (exp_r.status == ST_FILLED || exp_r.status == ST_PARTIAL)
                    n_fills++;
                if (exp_r.status == ST_REJECTED)
                    n_rejects++;
                if (got != exp_r) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0h/%0d/%0d/%0d/%0d/%0d got %0h/%0d/%0d/%0d/%0d/%0d",
                                 exp_r.id, exp_r.side, exp_r.price, exp_r.qty, exp_r.status,
                                 exp_r.last, got.id, got.side, got.price, got.qty,
                                 got.status, got.last);
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    int quiet = 0;
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add(input logic [15:0] id, input logic side, input logic [15:0] price,
                       input logic [15:0] qty);
        order_t o;
        o = '{id, side, price, qty};
        order_q.insert(order_q.size(), o);
    endtask

    task automatic wait_drained();
        while (order_q.size() > 0 || report_q.size() > 0 || s_axis_tvalid)
            @(posedge clk);
    endtask

    initial begin
        book_cnt[0] = 0;
        book_cnt[1] = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, zero quantity, full bid side, full sweep
        add(16'h0001, SIDE_BUY, 16'd0, 16'd1);
        add(16'hFFFE, SIDE_SELL, 16'hFFFF, 16'hFFFF);
        add(16'h0002, SIDE_BUY, 16'd500, 16'd0);
        add(16'h0003, SIDE_SELL, 16'd0, 16'd0);
        for (int k = 0; k < 15; k++)
            add(16'h0100 + 16'(k), SIDE_BUY, 16'd100 + 16'(k / 2) * 16'd50, 16'd10);
        add(16'h0200, SIDE_BUY, 16'd300, 16'd5);
        add(16'h0300, SIDE_SELL, 16'd0, 16'hFFFF);
        add(16'hFFFF, SIDE_BUY, 16'hFFFF, 16'hFFFF);
        add(16'h0400, SIDE_SELL, 16'd70, 16'd3);
        add(16'h0401, SIDE_BUY, 16'd80, 16'd1);
        add(16'h0000, SIDE_BUY, 16'd70, 16'd7);
        wait_drained();

        // Phase A: sender idles rarely, receiver often
        for (int k = 0; k < 110; k++)
            order_q.insert(order_q.size(), rand_order());
        wait_drained();

        // Phase B: swapped idling
        send_idle_pct = 72;
        recv_idle_pct = 14;
        for (int k = 0; k < 110; k++)
            order_q.insert(order_q.size(), rand_order());
        wait_drained();

        // Phase C: no idling, starting with a long receiver hold-off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 400;
        for (int k = 0; k < 120; k++)
            order_q.insert(order_q.size(), rand_order());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d orders, %0d reports (%0d fill reports, %0d rejects).",
                 orders_sent, reports_seen, n_fills, n_rejects);
        $display("Input stalled for %0d cycles; %0d mismatches.", stall_cycles, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lom_pkg.sv
rtl/lom_book_mem.sv
rtl/lom_ctrl.sv
rtl/limit_order_matcher.sv
verif/tb_limit_order_matcher.sv
